### sv/zoomed_sprite_chunk_expander_macros.svh
// ----------------------------------------------------------------------------
// Zoomed sprite chunk expander assertion macros
// Shorthand for the clocked properties used by the port checker. The macros
// expect clk and rst_n to be visible where they are used.
// ----------------------------------------------------------------------------
`ifndef ZOOMED_SPRITE_CHUNK_EXPANDER_MACROS_SVH
`define ZOOMED_SPRITE_CHUNK_EXPANDER_MACROS_SVH

// same-cycle implication, ignored while in reset
`define ZSCE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("zsce: same-cycle property failed");

// next-cycle implication, ignored while in reset
`define ZSCE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("zsce: next-cycle property failed");

// next-cycle implication, checked during reset as well
`define ZSCE_ASSERT_NXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("zsce: reset property failed");

`endif

### sv/zsce_pkg.sv
// ----------------------------------------------------------------------------
// zsce_pkg
// Types and constants shared by the zoomed sprite chunk expander modules.
// ----------------------------------------------------------------------------
`default_nettype none

package zsce_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_map;     // write the chunk map from the input item
    logic start;      // latch a sprite entry and restart the chunk walk
    logic issue;      // read the map word of the current chunk
    logic consume;    // retire the registered read result
    logic load_pend;  // move the read result into the pending record
    logic push;       // move the pending record into the output register
    logic push_last;  // the pushed record closes the sprite
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic item_is_map;
    logic tile_zero;
    logic rd_vld;
    logic code_ok;
    logic rd_last;
    logic issue_done;
    logic pend_valid;
    logic out_free;
  } status_t;

  localparam logic MODE_MAP_WRITE = 1'b0;

  localparam logic REG_X_OFFSET = 1'b0;
  localparam logic REG_Y_OFFSET = 1'b1;

  localparam logic [10:0] X_OFFSET_RESET = 11'h02c;  //  44
  localparam logic [10:0] Y_OFFSET_RESET = 11'h5c2;  // -574

  localparam logic [15:0] EMPTY_CODE = 16'hffff;

  localparam logic signed [11:0] COORD_LIMIT = 12'sh340;
  localparam logic signed [11:0] COORD_WRAP  = 12'sh400;

endpackage

`default_nettype wire

### sv/zsce_ctrl.sv
// ----------------------------------------------------------------------------
// zsce_ctrl
// Controller: accepts items, sequences the chunk walk and the hand-over of
// records from the pending stage to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module zsce_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  zsce_pkg::status_t status,
  output zsce_pkg::cmd_t    cmd
);
  import zsce_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a fresh non-empty chunk needs the pending record flushed first
  assign stall = status.rd_vld && status.code_ok && status.pend_valid && !status.out_free;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (status.item_is_map) begin
            cmd.wr_map = 1'b1;
          end else if (!status.tile_zero) begin
            cmd.start = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.issue     = !status.issue_done && !stall;
        cmd.consume   = status.rd_vld && !stall;
        cmd.load_pend = cmd.consume && status.code_ok;
        cmd.push      = status.rd_vld && status.code_ok && status.pend_valid &&
                        status.out_free;
        if (cmd.consume && status.rd_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!status.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (status.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/zsce_dp.sv
// ----------------------------------------------------------------------------
// zsce_dp
// Datapath: offset registers, sprite decode, chunk map memory, chunk walk
// counter, pending record and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module zsce_dp #(
  parameter int MAP_ADDR_BITS = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [10:0]       cfg_wdata,
  input  logic              in_mode,
  input  logic [16:0]       in_map_address,
  input  logic [15:0]       in_map_word,
  input  logic [31:0]       in_entry_word0,
  input  logic [31:0]       in_entry_word2,
  input  logic [31:0]       in_entry_word3,
  input  logic              out_ready,
  input  zsce_pkg::cmd_t    cmd,
  output zsce_pkg::status_t status,
  output logic              out_valid,
  output logic [15:0]       out_chunk_code,
  output logic [6:0]        out_palette,
  output logic              out_mirror_x,
  output logic              out_mirror_y,
  output logic [11:0]       out_pos_x,
  output logic [11:0]       out_pos_y,
  output logic [6:0]        out_size_x,
  output logic [6:0]        out_size_y,
  output logic [1:0]        out_layer_priority,
  output logic              out_last
);
  import zsce_pkg::*;

  localparam int MapDepth = 1 << MAP_ADDR_BITS;

  // split a chunk index into row and column for a 2x2 or 4x4 grid
  function automatic logic [3:0] split_rc(input logic [3:0] n, input logic dbl);
    logic [1:0] row;
    logic [1:0] col;
    row = dbl ? n[3:2] : {1'b0, n[1]};
    col = dbl ? n[1:0] : {1'b0, n[0]};
    return {row, col};
  endfunction

  // ---------------------------------------------------------------- config
  logic [10:0] x_off_r;
  logic [10:0] y_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_off_r <= X_OFFSET_RESET;
      y_off_r <= Y_OFFSET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_X_OFFSET: x_off_r <= cfg_wdata;
        REG_Y_OFFSET: y_off_r <= cfg_wdata;
        default:      x_off_r <= x_off_r;
      endcase
    end
  end

  // ---------------------------------------------------------------- decode
  logic [9:0]         y_neg;
  logic signed [11:0] y_sum;
  logic signed [11:0] y_adj;
  logic signed [11:0] x_raw;
  logic signed [11:0] x_adj;
  logic signed [11:0] x_pos;

  assign y_neg = 10'd0 - in_entry_word3[9:0];
  assign y_sum = $signed({2'b00, y_neg}) + $signed({y_off_r[10], y_off_r});
  assign y_adj = (y_sum > COORD_LIMIT) ? y_sum - COORD_WRAP : y_sum;
  assign x_raw = $signed({2'b00, in_entry_word2[9:0]});
  assign x_adj = (x_raw > COORD_LIMIT) ? x_raw - COORD_WRAP : x_raw;
  assign x_pos = x_adj - $signed({x_off_r[10], x_off_r});

  logic        fx_r;
  logic        fy_r;
  logic        dbl_r;
  logic [7:0]  zx_r;
  logic [7:0]  zy_r;
  logic [14:0] tile_r;
  logic [6:0]  pal_r;
  logic [1:0]  pri_r;
  logic [11:0] x_r;
  logic [11:0] y_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      fx_r   <= in_entry_word0[23];
      zx_r   <= {1'b0, in_entry_word0[22:16]} + 8'd1;
      tile_r <= in_entry_word0[14:0];
      pri_r  <= in_entry_word2[19:18];
      pal_r  <= in_entry_word2[17:11];
      dbl_r  <= in_entry_word3[18];
      fy_r   <= in_entry_word3[17];
      zy_r   <= {1'b0, in_entry_word3[16:10]} + 8'd1;
      x_r    <= x_pos;
      y_r    <= y_adj;
    end
  end

  // ------------------------------------------------------------ chunk walk
  logic [3:0] n_r;
  logic       issue_done_r;
  logic [3:0] last_n;
  logic [3:0] n_rc;
  logic [1:0] mask_rc;
  logic [1:0] px;
  logic [1:0] py;
  logic [3:0] chunk_off;
  logic [16:0] addr_full;
  logic [MAP_ADDR_BITS-1:0] rd_addr;

  assign last_n    = dbl_r ? 4'd15 : 4'd3;
  assign n_rc      = split_rc(n_r, dbl_r);
  assign mask_rc   = dbl_r ? 2'b11 : 2'b01;
  assign px        = fx_r ? (n_rc[1:0] ^ mask_rc) : n_rc[1:0];
  assign py        = fy_r ? (n_rc[3:2] ^ mask_rc) : n_rc[3:2];
  assign chunk_off = dbl_r ? ({py, 2'b00} + {2'b00, px}) : ({1'b0, py, 1'b0} + {2'b00, px});
  assign addr_full = {tile_r, 2'b00} + {13'd0, chunk_off};
  assign rd_addr   = addr_full[MAP_ADDR_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      n_r          <= 4'd0;
      issue_done_r <= 1'b0;
    end else if (cmd.issue) begin
      if (n_r == last_n) begin
        issue_done_r <= 1'b1;
      end else begin
        n_r <= n_r + 4'd1;
      end
    end
  end

  // ---------------------------------------------------------- chunk memory
  logic [15:0] map_mem [MapDepth];
  logic [15:0] rd_data_r;
  logic [3:0]  rd_n_r;
  logic        rd_vld_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_map) begin
      map_mem[in_map_address[MAP_ADDR_BITS-1:0]] <= in_map_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data_r <= map_mem[rd_addr];
      rd_n_r    <= n_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (cmd.issue) begin
      rd_vld_r <= 1'b1;
    end else if (cmd.consume) begin
      rd_vld_r <= 1'b0;
    end
  end

  // -------------------------------------------------------- pending record
  logic [15:0] pend_code_r;
  logic [3:0]  pend_n_r;
  logic        pend_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.load_pend) begin
      pend_code_r <= rd_data_r;
      pend_n_r    <= rd_n_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.load_pend) begin
      pend_valid_r <= 1'b1;
    end else if (cmd.push) begin
      pend_valid_r <= 1'b0;
    end
  end

  // --------------------------------------------------- zoomed geometry
  logic [3:0] pend_rc;
  logic [9:0] kx;
  logic [9:0] k1x;
  logic [9:0] jy;
  logic [9:0] j1y;
  logic [9:0] kx_s;
  logic [9:0] k1x_s;
  logic [9:0] jy_s;
  logic [9:0] j1y_s;

  assign pend_rc = split_rc(pend_n_r, dbl_r);
  assign kx      = {8'd0, pend_rc[1:0]} * {2'b00, zx_r};
  assign k1x     = ({7'd0, {1'b0, pend_rc[1:0]} + 3'd1}) * {2'b00, zx_r};
  assign jy      = {8'd0, pend_rc[3:2]} * {2'b00, zy_r};
  assign j1y     = ({7'd0, {1'b0, pend_rc[3:2]} + 3'd1}) * {2'b00, zy_r};
  assign kx_s    = dbl_r ? (kx  >> 2) : (kx  >> 1);
  assign k1x_s   = dbl_r ? (k1x >> 2) : (k1x >> 1);
  assign jy_s    = dbl_r ? (jy  >> 2) : (jy  >> 1);
  assign j1y_s   = dbl_r ? (j1y >> 2) : (j1y >> 1);

  // ------------------------------------------------------- output register
  logic        out_valid_r;
  logic [15:0] out_code_r;
  logic [6:0]  out_pal_r;
  logic        out_mx_r;
  logic        out_my_r;
  logic [11:0] out_px_r;
  logic [11:0] out_py_r;
  logic [9:0]  out_sx_full;
  logic [9:0]  out_sy_full;
  logic [6:0]  out_sx_r;
  logic [6:0]  out_sy_r;
  logic [1:0]  out_pri_r;
  logic        out_last_r;

  assign out_sx_full = k1x_s - kx_s;
  assign out_sy_full = j1y_s - jy_s;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_code_r <= pend_code_r;
      out_pal_r  <= pal_r;
      out_mx_r   <= ~fx_r;
      out_my_r   <= fy_r;
      out_px_r   <= x_r + {2'b00, kx_s};
      out_py_r   <= y_r + {2'b00, jy_s};
      out_sx_r   <= out_sx_full[6:0];
      out_sy_r   <= out_sy_full[6:0];
      out_pri_r  <= pri_r;
      out_last_r <= cmd.push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_chunk_code     = out_code_r;
  assign out_palette        = out_pal_r;
  assign out_mirror_x       = out_mx_r;
  assign out_mirror_y       = out_my_r;
  assign out_pos_x          = out_px_r;
  assign out_pos_y          = out_py_r;
  assign out_size_x         = out_sx_r;
  assign out_size_y         = out_sy_r;
  assign out_layer_priority = out_pri_r;
  assign out_last           = out_last_r;

  // ---------------------------------------------------------------- status
  always_comb begin
    status.item_is_map = (in_mode == MODE_MAP_WRITE);
    status.tile_zero   = (in_entry_word0[14:0] == 15'd0);
    status.rd_vld      = rd_vld_r;
    status.code_ok     = (rd_data_r != EMPTY_CODE);
    status.rd_last     = (rd_n_r == last_n);
    status.issue_done  = issue_done_r;
    status.pend_valid  = pend_valid_r;
    status.out_free    = !out_valid_r || out_ready;
  end

endmodule

`default_nettype wire

### sv/zoomed_sprite_chunk_expander.sv
// Zoomed sprite chunk expander. An input transaction with mode 0 writes one
// 16-bit word into the chunk map. Mode 1 decodes a sprite entry and, unless
// its tile is zero, walks its 2x2 or 4x4 chunk grid, reading one chunk map
// word per cycle while the output side keeps up, through the single read
// port of the map; every chunk whose code is not 0xffff yields one result
// transaction, and the final one carries last. A sprite occupies the block
// while its results are drained, longer while out_ready is held low. The
// next item is taken once the walk ends and the final record has moved
// into the output register, where it may still wait. The chunk map has no
// reset: read only entries already written. The user must write x_offset
// and y_offset through cfg_we/cfg_index/cfg_wdata only while the block is
// idle; the block itself does not enforce this.
`default_nettype none

module zoomed_sprite_chunk_expander #(
  parameter int MAP_ADDR_BITS = 17
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [16:0] in_map_address,
  input  logic [15:0] in_map_word,
  input  logic [31:0] in_entry_word0,
  input  logic [31:0] in_entry_word2,
  input  logic [31:0] in_entry_word3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_chunk_code,
  output logic [6:0]  out_palette,
  output logic        out_mirror_x,
  output logic        out_mirror_y,
  output logic [11:0] out_pos_x,
  output logic [11:0] out_pos_y,
  output logic [6:0]  out_size_x,
  output logic [6:0]  out_size_y,
  output logic [1:0]  out_layer_priority,
  output logic        out_last
);
  import zsce_pkg::*;

  cmd_t    cmd;
  status_t status;

  zsce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  zsce_dp #(
    .MAP_ADDR_BITS (MAP_ADDR_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_mode            (in_mode),
    .in_map_address     (in_map_address),
    .in_map_word        (in_map_word),
    .in_entry_word0     (in_entry_word0),
    .in_entry_word2     (in_entry_word2),
    .in_entry_word3     (in_entry_word3),
    .out_ready          (out_ready),
    .cmd                (cmd),
    .status             (status),
    .out_valid          (out_valid),
    .out_chunk_code     (out_chunk_code),
    .out_palette        (out_palette),
    .out_mirror_x       (out_mirror_x),
    .out_mirror_y       (out_mirror_y),
    .out_pos_x          (out_pos_x),
    .out_pos_y          (out_pos_y),
    .out_size_x         (out_size_x),
    .out_size_y         (out_size_y),
    .out_layer_priority (out_layer_priority),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire

### sv/zsce_checker.sv
// ----------------------------------------------------------------------------
// zsce_checker
// Port-level checks on the zoomed sprite chunk expander, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "zoomed_sprite_chunk_expander_macros.svh"

module zsce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_chunk_code,
  input logic [6:0]  out_size_x,
  input logic [6:0]  out_size_y
);

  // hold a stalled result transaction
  `ZSCE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `ZSCE_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_chunk_code))

  // empty chunks never leave the block
  `ZSCE_ASSERT_IMP(a_no_empty, out_valid, out_chunk_code != 16'hffff)

  // a chunk is at most half of a fully zoomed 128-pixel sprite
  `ZSCE_ASSERT_IMP(a_size_max, out_valid, out_size_x <= 7'd64 && out_size_y <= 7'd64)

  // reset leaves the block ready with nothing to deliver
  `ZSCE_ASSERT_NXT_ALWAYS(a_reset_idle, !rst_n, !out_valid && in_ready)

endmodule

bind zoomed_sprite_chunk_expander zsce_checker u_zsce_checker (.*);

`default_nettype wire

### sim/zoomed_sprite_chunk_expander_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zoomed sprite chunk expander testbench
// Drives chunk map writes and sprite entries through the valid/ready input
// channel and checks every chunk record against a behavioural predictor or a
// hand-written record. A short directed list covers field extremes, tile zero,
// all-empty sprites and the signed coordinate edge. Random sprite groups
// follow, each one preceded by the map writes it needs. The run steps through
// several offset settings, with bursty input and a stalling output receiver.
// ----------------------------------------------------------------------------
module zoomed_sprite_chunk_expander_test;
  import zsce_pkg::*;

  localparam logic MODE_SPRITE   = ~MODE_MAP_WRITE;
  localparam int   CYCLE_LIMIT   = 400000;
  localparam int   ITEM_GOAL     = 430;
  localparam int   RANDOM_PHASES = 8;
  localparam int   HOLD_CYCLES   = 300;
  localparam int   SETTLE_CYCLES = 40;

  typedef struct packed {
    logic        mode;
    logic [16:0] map_address;
    logic [15:0] map_word;
    logic [31:0] entry_word0;
    logic [31:0] entry_word2;
    logic [31:0] entry_word3;
  } expander_item_t;

  typedef struct packed {
    logic [15:0] chunk_code;
    logic [6:0]  palette;
    logic        mirror_x;
    logic        mirror_y;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [6:0]  size_x;
    logic [6:0]  size_y;
    logic [1:0]  layer_priority;
    logic        last;
  } chunk_rec_t;

  typedef enum logic [1:0] {
    BY_MODEL,
    NO_RECORD,
    ONE_RECORD
  } row_check_t;

  typedef struct packed {
    expander_item_t item;
    row_check_t     chk;
    chunk_rec_t     rec;
  } stim_row_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_we      = 1'b0;
  logic        cfg_index   = REG_X_OFFSET;
  logic [10:0] cfg_wdata   = '0;
  logic        in_valid    = 1'b0;
  logic        in_mode     = MODE_MAP_WRITE;
  logic [16:0] in_map_address = '0;
  logic [15:0] in_map_word = '0;
  logic [31:0] in_entry_word0 = '0;
  logic [31:0] in_entry_word2 = '0;
  logic [31:0] in_entry_word3 = '0;
  logic        out_ready   = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [15:0] out_chunk_code;
  logic [6:0]  out_palette;
  logic        out_mirror_x;
  logic        out_mirror_y;
  logic [11:0] out_pos_x;
  logic [11:0] out_pos_y;
  logic [6:0]  out_size_x;
  logic [6:0]  out_size_y;
  logic [1:0]  out_layer_priority;
  logic        out_last;

  // predictor state
  logic [15:0]        tile_codes [0:131071];
  logic signed [10:0] x_offset_q = X_OFFSET_RESET;
  logic signed [10:0] y_offset_q = Y_OFFSET_RESET;
  chunk_rec_t         pending_chunks[$];

  // stimulus bookkeeping
  bit map_written [0:131071];
  int tile_pool [8] = '{1, 2, 3, 'h10, 'h11, 'h155, 'h4000, 'h7ffc};
  int burst_left  = 0;
  int items_sent  = 0;
  int error_count = 0;
  int cycle_count = 0;
  chunk_rec_t want;

  // receiver state
  int rx_hold  = 0;
  int rx_taken = 0;
  int rx_mode  = 0;
  int rx_left  = 0;
  bit rx_held  = 1'b0;

  zoomed_sprite_chunk_expander #(
    .MAP_ADDR_BITS(17)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_map_address    (in_map_address),
    .in_map_word       (in_map_word),
    .in_entry_word0    (in_entry_word0),
    .in_entry_word2    (in_entry_word2),
    .in_entry_word3    (in_entry_word3),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_chunk_code    (out_chunk_code),
    .out_palette       (out_palette),
    .out_mirror_x      (out_mirror_x),
    .out_mirror_y      (out_mirror_y),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_size_x        (out_size_x),
    .out_size_y        (out_size_y),
    .out_layer_priority(out_layer_priority),
    .out_last          (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Update the map for a write; for a sprite, walk its chunk grid in flip order
  // and queue one record per non-empty chunk when keep is set.
  function automatic void expand_item(input expander_item_t it, input bit keep);
    int         tile, dim, zx, zy, x, y, fx, fy, px, py;
    logic [16:0] addr;
    logic [15:0] code;
    chunk_rec_t r, prev;
    bit         have_prev;
    have_prev = 1'b0;
    if (it.mode == MODE_MAP_WRITE) begin
      tile_codes[it.map_address] = it.map_word;
      return;
    end
    tile = it.entry_word0[14:0];
    if (tile == 0) return;
    fx  = it.entry_word0[23];
    fy  = it.entry_word3[17];
    zx  = it.entry_word0[22:16] + 1;
    zy  = it.entry_word3[16:10] + 1;
    dim = it.entry_word3[18] ? 4 : 2;
    x   = it.entry_word2[9:0];
    y   = ('h400 - it.entry_word3[9:0]) & 'h3ff;
    y   = y + y_offset_q;
    if (x > COORD_LIMIT) x = x - COORD_WRAP;
    if (y > COORD_LIMIT) y = y - COORD_WRAP;
    x = x - x_offset_q;
    for (int j = 0; j < dim; j++) begin
      for (int k = 0; k < dim; k++) begin
        px   = fx ? dim - 1 - k : k;
        py   = fy ? dim - 1 - j : j;
        addr = 17'(tile * 4 + px + py * dim);
        code = tile_codes[addr];
        if (code == EMPTY_CODE) continue;
        r.chunk_code     = code;
        r.palette        = it.entry_word2[17:11];
        r.mirror_x       = ~fx[0];
        r.mirror_y       = fy[0];
        r.pos_x          = 12'(x + (k * zx) / dim);
        r.pos_y          = 12'(y + (j * zy) / dim);
        r.size_x         = 7'(((k + 1) * zx) / dim - (k * zx) / dim);
        r.size_y         = 7'(((j + 1) * zy) / dim - (j * zy) / dim);
        r.layer_priority = it.entry_word2[19:18];
        r.last           = 1'b0;
        // hold each record back one step so the final one can take last
        if (have_prev && keep) pending_chunks.push_back(prev);
        prev      = r;
        have_prev = 1'b1;
      end
    end
    if (have_prev && keep) begin
      prev.last = 1'b1;
      pending_chunks.push_back(prev);
    end
  endfunction

  function automatic expander_item_t noise_item();
    expander_item_t it;
    it.mode        = 1'($urandom_range(0, 1));
    it.map_address = 17'($urandom);
    it.map_word    = 16'($urandom);
    it.entry_word0 = $urandom;
    it.entry_word2 = $urandom;
    it.entry_word3 = $urandom;
    return it;
  endfunction

  function automatic stim_row_t make_row(input logic mode, input logic [16:0] addr,
                                         input logic [15:0] word, input logic [31:0] w0,
                                         input logic [31:0] w2, input logic [31:0] w3,
                                         input row_check_t chk, input chunk_rec_t rec);
    stim_row_t row;
    row.item.mode        = mode;
    row.item.map_address = addr;
    row.item.map_word    = word;
    row.item.entry_word0 = w0;
    row.item.entry_word2 = w2;
    row.item.entry_word3 = w3;
    row.chk              = chk;
    row.rec              = rec;
    return row;
  endfunction

  // Offer one input transaction, idling between bursts, and predict on acceptance.
  task automatic offer_item(input expander_item_t it, input row_check_t chk,
                            input chunk_rec_t rec);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    if (it.mode == MODE_MAP_WRITE) map_written[it.map_address] = 1'b1;
    in_valid       <= 1'b1;
    in_mode        <= it.mode;
    in_map_address <= it.map_address;
    in_map_word    <= it.map_word;
    in_entry_word0 <= it.entry_word0;
    in_entry_word2 <= it.entry_word2;
    in_entry_word3 <= it.entry_word3;
    do @(posedge clk); while (in_ready !== 1'b1);
    expand_item(it, chk == BY_MODEL);
    if (chk == ONE_RECORD) pending_chunks.push_back(rec);
    items_sent++;
  endtask

  // Drop valid, wait for every expected record, then let a trailing walk finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_chunks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want_v, got_v);
      error_count++;
    end
  endtask

  initial begin
    stim_row_t      directed_rows[$];
    chunk_rec_t     glance;
    expander_item_t it, wr;
    logic [10:0]    xo, yo;
    logic [16:0]    addr;
    int             tile, dim, goal, n_directed;
    bit             all_empty;

    glance                = '0;
    glance.chunk_code     = 16'h1234;
    glance.palette        = 7'h2a;
    glance.mirror_x       = 1'b1;
    glance.pos_x          = 12'd212;
    glance.pos_y          = 12'd100;
    glance.size_x         = 7'd32;
    glance.size_y         = 7'd32;
    glance.layer_priority = 2'd2;
    glance.last           = 1'b1;

    // one live chunk out of four, reset offsets: a single record to read off
    directed_rows.push_back(make_row(MODE_MAP_WRITE, 17'h00040, 16'h1234, '0, '0, '0,
                                     NO_RECORD, '0));
    directed_rows.push_back(make_row(MODE_MAP_WRITE, 17'h00041, EMPTY_CODE, '0, '0, '0,
                                     NO_RECORD, '0));
    directed_rows.push_back(make_row(MODE_MAP_WRITE, 17'h00042, EMPTY_CODE, '0, '0, '0,
                                     NO_RECORD, '0));
    directed_rows.push_back(make_row(MODE_MAP_WRITE, 17'h00043, EMPTY_CODE, '0, '0, '0,
                                     NO_RECORD, '0));
    directed_rows.push_back(make_row(MODE_SPRITE, '0, '0, 32'h003f0010, 32'h00095100,
                                     32'h0000fd5e, ONE_RECORD, glance));
    // tile zero with every other bit set
    directed_rows.push_back(make_row(MODE_SPRITE, 17'h1ffff, 16'hffff, 32'hffff8000,
                                     32'hffffffff, 32'hffffffff, NO_RECORD, '0));
    directed_rows.push_back(make_row(MODE_MAP_WRITE, 17'h1fffc, 16'h0000, '0, '0, '0,
                                     NO_RECORD, '0));
    directed_rows.push_back(make_row(MODE_MAP_WRITE, 17'h1fffd, 16'h8001, '0, '0, '0,
                                     NO_RECORD, '0));
    directed_rows.push_back(make_row(MODE_MAP_WRITE, 17'h1fffe, 16'h7ffe, '0, '0, '0,
                                     NO_RECORD, '0));
    directed_rows.push_back(make_row(MODE_MAP_WRITE, 17'h1ffff, 16'hfffe, '0, '0, '0,
                                     NO_RECORD, '0));
    // top tile: full zoom and both flips, then minimum zoom, then the 0x340 edge
    directed_rows.push_back(make_row(MODE_SPRITE, '0, '0, 32'hffffffff, 32'hffffffff,
                                     32'hfffbffff, BY_MODEL, '0));
    directed_rows.push_back(make_row(MODE_SPRITE, '0, '0, 32'h00007fff, 32'h00000341,
                                     32'h00000000, BY_MODEL, '0));
    directed_rows.push_back(make_row(MODE_SPRITE, '0, '0, 32'h00807fff, 32'h00040340,
                                     32'h00020200, BY_MODEL, '0));
    // every chunk empty
    directed_rows.push_back(make_row(MODE_MAP_WRITE, 17'h00040, EMPTY_CODE, '0, '0, '0,
                                     NO_RECORD, '0));
    directed_rows.push_back(make_row(MODE_SPRITE, '0, '0, 32'h003f0010, 32'h00095100,
                                     32'h0000fd5e, NO_RECORD, '0));
    n_directed = directed_rows.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      offer_item(directed_rows[i].item, directed_rows[i].chk, directed_rows[i].rec);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin xo = 11'h400; yo = 11'h400; end
        1: begin xo = 11'h3ff; yo = 11'h3ff; end
        2: begin xo = 11'h400; yo = 11'h3ff; end
        3: begin xo = 11'h3ff; yo = 11'h400; end
        4: begin xo = 11'h000; yo = 11'h000; end
        default: begin
          xo = 11'($urandom_range(0, 2047));
          yo = 11'($urandom_range(0, 2047));
        end
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= REG_X_OFFSET;
      cfg_wdata <= xo;
      @(posedge clk);
      cfg_index <= REG_Y_OFFSET;
      cfg_wdata <= yo;
      @(posedge clk);
      cfg_we     <= 1'b0;
      x_offset_q  = xo;
      y_offset_q  = yo;

      goal = n_directed + (ITEM_GOAL - n_directed) * (ph + 1) / RANDOM_PHASES;
      while (items_sent < goal) begin
        case ($urandom_range(0, 9))
          0: begin
            it                   = noise_item();
            it.mode              = MODE_SPRITE;
            it.entry_word0[14:0] = '0;
            offer_item(it, BY_MODEL, '0);
          end
          1: begin
            it      = noise_item();
            it.mode = MODE_MAP_WRITE;
            offer_item(it, BY_MODEL, '0);
          end
          default: begin
            case ($urandom_range(0, 3))
              0:       tile = $urandom_range(1, 'h7fff);
              1:       tile = 'h7ffd + $urandom_range(0, 2);
              default: tile = tile_pool[$urandom_range(0, 7)];
            endcase
            it                   = noise_item();
            it.mode              = MODE_SPRITE;
            it.entry_word0[14:0] = 15'(tile);
            dim                  = it.entry_word3[18] ? 4 : 2;
            all_empty            = ($urandom_range(0, 11) == 0);
            // write every word the walk will read before the sprite goes in
            for (int py = 0; py < dim; py++) begin
              for (int px = 0; px < dim; px++) begin
                addr = 17'(tile * 4 + px + py * dim);
                if (!map_written[addr] || all_empty || $urandom_range(0, 4) == 0) begin
                  wr             = noise_item();
                  wr.mode        = MODE_MAP_WRITE;
                  wr.map_address = addr;
                  if (all_empty || $urandom_range(0, 3) == 0) wr.map_word = EMPTY_CODE;
                  offer_item(wr, BY_MODEL, '0);
                end
              end
            end
            offer_item(it, BY_MODEL, '0);
          end
        endcase
      end
    end
    drain();

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver: random stall patterns, plus one long hold-off to back up the block.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold   <= 0;
      rx_taken  <= 0;
      rx_mode   <= 0;
      rx_left   <= 0;
      rx_held   <= 1'b0;
    end else begin
      if (out_valid && out_ready) rx_taken <= rx_taken + 1;
      if (rx_hold != 0) begin
        out_ready <= 1'b0;
        rx_hold   <= rx_hold - 1;
      end else if (!rx_held && rx_taken >= 20) begin
        rx_held   <= 1'b1;
        rx_hold   <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode <= $urandom_range(0, 3);
          rx_left <= $urandom_range(16, 96);
        end else begin
          rx_left <= rx_left - 1;
        end
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 4) != 0);
          default: out_ready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_chunks.size() == 0) begin
        $error("unexpected result transaction: chunk_code %0h", out_chunk_code);
        error_count++;
      end else begin
        want = pending_chunks.pop_front();
        check_field("chunk_code", want.chunk_code, out_chunk_code);
        check_field("palette", want.palette, out_palette);
        check_field("mirror_x", want.mirror_x, out_mirror_x);
        check_field("mirror_y", want.mirror_y, out_mirror_y);
        check_field("pos_x", want.pos_x, out_pos_x);
        check_field("pos_y", want.pos_y, out_pos_y);
        check_field("size_x", want.size_x, out_size_x);
        check_field("size_y", want.size_y, out_size_y);
        check_field("layer_priority", want.layer_priority, out_layer_priority);
        check_field("last", want.last, out_last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
